// ===== hw/rtl/erm_pkg.sv =====
`default_nettype none
package erm_pkg;

  // Coordinate format
  localparam int COORD_INT_BITS = 12;
  localparam int FRAC_BITS      = 4;
  localparam int COORD_W        = COORD_INT_BITS + FRAC_BITS;
  localparam int PIX_W          = COORD_INT_BITS;
  localparam int VAL_W          = 8;

  // Doubled coordinates, their squares and the root radicand
  localparam int DBL_W = COORD_W + 1;
  localparam int SQ_W  = 2 * DBL_W + 1;
  localparam int RAD_W = 2 * DBL_W;

  // Accumulators and result
  localparam int SUM_W     = 32;
  localparam int CNT_W     = 25;
  localparam int MEAN_W    = 16;
  localparam int MEAN_FRAC = 8;

  // Register map
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_X = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_Y = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_LEFT_X   = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_LEFT_Y   = CFG_IDX_W'(3);
  localparam logic [CFG_IDX_W-1:0] REG_RIGHT_X  = CFG_IDX_W'(4);
  localparam logic [CFG_IDX_W-1:0] REG_RIGHT_Y  = CFG_IDX_W'(5);
  localparam logic [CFG_IDX_W-1:0] REG_TOP_Y    = CFG_IDX_W'(6);
  localparam logic [CFG_IDX_W-1:0] REG_BOTTOM_Y = CFG_IDX_W'(7);

  typedef struct packed {
    logic [PIX_W-1:0] pixel_x;
    logic [PIX_W-1:0] pixel_y;
    logic [VAL_W-1:0] pixel_value;
    logic             last;
  } pixel_beat_t;

  typedef struct packed {
    logic [MEAN_W-1:0] mean_value;
    logic [CNT_W-1:0]  inside_count;
    logic              empty_res;
  } result_beat_t;

endpackage
`default_nettype wire

// ===== hw/rtl/erm_dist.sv =====
`default_nettype none
// Distance unit: squares dx and dy by shift-and-add, one multiplier bit per
// cycle, then takes the truncated square root of a quarter of the sum, one
// root bit per cycle.
module erm_dist (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [erm_pkg::DBL_W-1:0] dx,
  input  logic [erm_pkg::DBL_W-1:0] dy,
  output logic                      done,
  output logic [erm_pkg::DBL_W-1:0] root
);
  import erm_pkg::*;

  localparam int CW = $clog2(DBL_W);
  localparam logic [CW-1:0] CNT_LAST = CW'(DBL_W - 1);
  localparam int RW = DBL_W + 2;

  localparam logic [1:0] P_IDLE = 2'd0;
  localparam logic [1:0] P_MUL  = 2'd1;
  localparam logic [1:0] P_ROOT = 2'd2;

  logic [1:0]       phase;
  logic [CW-1:0]    cnt;
  logic [DBL_W-1:0] dxr, dyr, mx, my;
  logic [SQ_W-1:0]  acc, acc_next;
  logic [RAD_W-1:0] rad;
  logic [RW-1:0]    rem;
  logic [RW+1:0]    remw, trial;
  logic             fits;

  // One shift-add step for both squares at once
  always_comb begin
    acc_next = {acc[SQ_W-2:0], 1'b0};
    if (mx[DBL_W-1]) acc_next = acc_next + SQ_W'(dxr);
    if (my[DBL_W-1]) acc_next = acc_next + SQ_W'(dyr);
  end

  // One restoring square root step
  always_comb begin
    remw  = {rem, rad[RAD_W-1:RAD_W-2]};
    trial = (RW+2)'({root, 2'b01});
    fits  = remw >= trial;
  end

  // Sequence the two phases
  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= P_IDLE;
      cnt   <= '0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (phase)
        P_IDLE: begin
          if (start) begin
            phase <= P_MUL;
            cnt   <= '0;
          end
        end
        P_MUL: begin
          cnt <= cnt + CW'(1);
          if (cnt == CNT_LAST) begin
            phase <= P_ROOT;
            cnt   <= '0;
          end
        end
        P_ROOT: begin
          cnt <= cnt + CW'(1);
          if (cnt == CNT_LAST) begin
            phase <= P_IDLE;
            done  <= 1'b1;
          end
        end
        default: phase <= P_IDLE;
      endcase
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    case (phase)
      P_IDLE: begin
        if (start) begin
          dxr <= dx;
          dyr <= dy;
          mx  <= dx;
          my  <= dy;
          acc <= '0;
        end
      end
      P_MUL: begin
        acc <= acc_next;
        mx  <= {mx[DBL_W-2:0], 1'b0};
        my  <= {my[DBL_W-2:0], 1'b0};
        if (cnt == CNT_LAST) begin
          rad  <= {1'b0, acc_next[SQ_W-1:2]};
          rem  <= '0;
          root <= '0;
        end
      end
      P_ROOT: begin
        rad <= {rad[RAD_W-3:0], 2'b00};
        if (fits) begin
          rem  <= RW'(remw - trial);
          root <= {root[DBL_W-2:0], 1'b1};
        end else begin
          rem  <= remw[RW-1:0];
          root <= {root[DBL_W-2:0], 1'b0};
        end
      end
      default: ;
    endcase
  end

endmodule
`default_nettype wire

// ===== hw/rtl/erm_div.sv =====
`default_nettype none
// Mean divider: (sum << MEAN_FRAC) / count by restoring division, one
// quotient bit per cycle. The caller guarantees the quotient fits MEAN_W bits.
module erm_div (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [erm_pkg::SUM_W-1:0]  sum,
  input  logic [erm_pkg::CNT_W-1:0]  divisor,
  output logic                       done,
  output logic [erm_pkg::MEAN_W-1:0] quot
);
  import erm_pkg::*;

  localparam int CW = $clog2(MEAN_W);
  localparam logic [CW-1:0] CNT_LAST = CW'(MEAN_W - 1);

  logic              busy;
  logic [CW-1:0]     cnt;
  logic [CNT_W-1:0]  rem, dvs;
  logic [MEAN_W-1:0] lo;
  logic [CNT_W:0]    remw;
  logic              fits;

  always_comb begin
    remw = {rem, lo[MEAN_W-1]};
    fits = remw >= {1'b0, dvs};
  end

  // Control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (!busy) begin
        if (start) begin
          busy <= 1'b1;
          cnt  <= '0;
        end
      end else begin
        cnt <= cnt + CW'(1);
        if (cnt == CNT_LAST) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Shift in one dividend bit, subtract where it fits
  always_ff @(posedge clk) begin
    if (!busy) begin
      if (start) begin
        rem  <= CNT_W'(sum[SUM_W-1:MEAN_W-MEAN_FRAC]);
        lo   <= {sum[MEAN_W-MEAN_FRAC-1:0], {MEAN_FRAC{1'b0}}};
        dvs  <= divisor;
        quot <= '0;
      end
    end else begin
      lo <= {lo[MEAN_W-2:0], 1'b0};
      if (fits) begin
        rem  <= CNT_W'(remw - {1'b0, dvs});
        quot <= {quot[MEAN_W-2:0], 1'b1};
      end else begin
        rem  <= remw[CNT_W-1:0];
        quot <= {quot[MEAN_W-2:0], 1'b0};
      end
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/ellipse_region_mean.sv =====
`default_nettype none
// Mean grey level of the pixels inside an ellipse. One pixel is taken at a
// time. A pixel outside the bounding box (or with the center left of the left
// vertex) passes from the prepare state straight to the accumulate state; a
// pixel inside the box first runs the two distance units, which square
// serially and then extract the root one bit a cycle, both foci in parallel.
// A pixel marked last then goes through the finish state, and through the
// bit-serial mean divider when the region is not empty and the mean does
// not saturate. A finished result sits in the output register while new
// pixels are accepted; a further result waits until it is taken.
module ellipse_region_mean (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  erm_pkg::pixel_beat_t          in_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output erm_pkg::result_beat_t         out_data,
  input  logic                          cfg_we,
  input  logic [erm_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [erm_pkg::COORD_W-1:0]   cfg_data
);
  import erm_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_PREP = 3'd1;
  localparam logic [2:0] S_GO   = 3'd2;
  localparam logic [2:0] S_WAIT = 3'd3;
  localparam logic [2:0] S_ACC  = 3'd4;
  localparam logic [2:0] S_FIN  = 3'd5;
  localparam logic [2:0] S_DIV  = 3'd6;
  localparam logic [2:0] S_OUT  = 3'd7;

  function automatic logic [DBL_W-1:0] absdiff(input logic [DBL_W-1:0] a,
                                               input logic [DBL_W-1:0] b);
    absdiff = (a >= b) ? a - b : b - a;
  endfunction

  logic [COORD_W-1:0] center_x, center_y, left_x, left_y;
  logic [COORD_W-1:0] right_x, right_y, top_y, bottom_y;

  logic [2:0]        state;
  logic [PIX_W-1:0]  px, py;
  logic [VAL_W-1:0]  pv;
  logic              plast;
  logic [DBL_W-1:0]  dx1, dy1, dx2, dy2, two_a;
  logic              hit;
  logic [SUM_W-1:0]  sum;
  logic [CNT_W-1:0]  count;
  logic [MEAN_W-1:0] mean;
  logic              empty;

  logic              box_ok;
  logic [DBL_W-1:0]  x2, y2, f1x, f1y, f2x, f2y;
  logic              d1_done, d2_done, div_done, div_start, sat;
  logic [DBL_W-1:0]  d1, d2;
  logic [DBL_W:0]    dsum;
  logic [SUM_W:0]    sum_add;
  logic [MEAN_W-1:0] quot;
  logic              out_load;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      center_x <= '0;
      center_y <= '0;
      left_x   <= '0;
      left_y   <= '0;
      right_x  <= '0;
      right_y  <= '0;
      top_y    <= '0;
      bottom_y <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_CENTER_X: center_x <= cfg_data;
        REG_CENTER_Y: center_y <= cfg_data;
        REG_LEFT_X:   left_x   <= cfg_data;
        REG_LEFT_Y:   left_y   <= cfg_data;
        REG_RIGHT_X:  right_x  <= cfg_data;
        REG_RIGHT_Y:  right_y  <= cfg_data;
        REG_TOP_Y:    top_y    <= cfg_data;
        REG_BOTTOM_Y: bottom_y <= cfg_data;
        default: ;
      endcase
    end
  end

  // Box test and doubled coordinates of pixel and foci
  always_comb begin
    box_ok = (px >= left_x[COORD_W-1:FRAC_BITS]) && (px <= right_x[COORD_W-1:FRAC_BITS]) &&
             (py >= top_y[COORD_W-1:FRAC_BITS]) && (py <= bottom_y[COORD_W-1:FRAC_BITS]) &&
             (center_x >= left_x);
    x2  = {px, {(FRAC_BITS + 1){1'b0}}};
    y2  = {py, {(FRAC_BITS + 1){1'b0}}};
    f1x = {1'b0, center_x} + {1'b0, left_x};
    f1y = {1'b0, center_y} + {1'b0, left_y};
    f2x = {1'b0, center_x} + {1'b0, right_x};
    f2y = {1'b0, center_y} + {1'b0, right_y};
  end

  erm_dist u_dist1 (
    .clk   (clk),
    .rst   (rst),
    .start (state == S_GO),
    .dx    (dx1),
    .dy    (dy1),
    .done  (d1_done),
    .root  (d1)
  );

  erm_dist u_dist2 (
    .clk   (clk),
    .rst   (rst),
    .start (state == S_GO),
    .dx    (dx2),
    .dy    (dy2),
    .done  (d2_done),
    .root  (d2)
  );

  // Saturating accumulate and mean overflow check
  always_comb begin
    dsum      = {1'b0, d1} + {1'b0, d2};
    sum_add   = {1'b0, sum} + (SUM_W + 1)'(pv);
    sat       = {1'b0, sum} >= {count, {MEAN_FRAC{1'b0}}};
    div_start = (state == S_FIN) && (count != '0) && !sat;
    out_load  = (state == S_OUT) && (!out_valid || out_ready);
  end

  erm_div u_div (
    .clk     (clk),
    .rst     (rst),
    .start   (div_start),
    .sum     (sum),
    .divisor (count),
    .done    (div_done),
    .quot    (quot)
  );

  assign in_ready = (state == S_IDLE);

  // Sequencer and accumulators
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      sum   <= '0;
      count <= '0;
    end else begin
      case (state)
        S_IDLE: if (in_valid) state <= S_PREP;
        S_PREP: state <= box_ok ? S_GO : S_ACC;
        S_GO:   state <= S_WAIT;
        S_WAIT: if (d1_done && d2_done) state <= S_ACC;
        S_ACC: begin
          if (hit) begin
            sum <= sum_add[SUM_W] ? '1 : sum_add[SUM_W-1:0];
            if (count != '1) count <= count + CNT_W'(1);
          end
          state <= plast ? S_FIN : S_IDLE;
        end
        S_FIN:  state <= div_start ? S_DIV : S_OUT;
        S_DIV:  if (div_done) state <= S_OUT;
        S_OUT: begin
          if (out_load) begin
            sum   <= '0;
            count <= '0;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Pixel beat, focus offsets, hit flag and mean
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      px    <= in_data.pixel_x;
      py    <= in_data.pixel_y;
      pv    <= in_data.pixel_value;
      plast <= in_data.last;
    end
    if (state == S_PREP) begin
      dx1   <= absdiff(x2, f1x);
      dy1   <= absdiff(y2, f1y);
      dx2   <= absdiff(x2, f2x);
      dy2   <= absdiff(y2, f2y);
      two_a <= {center_x - left_x, 1'b0};
      hit   <= 1'b0;
    end
    if (state == S_WAIT && d1_done && d2_done) hit <= dsum <= {1'b0, two_a};
    if (state == S_FIN) begin
      empty <= (count == '0);
      mean  <= (count == '0) ? '0 : (sat ? '1 : '0);
    end
    if (state == S_DIV && div_done) mean <= quot;
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data.mean_value   <= mean;
      out_data.inside_count <= count;
      out_data.empty_res    <= empty;
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/erm_check.sv =====
`default_nettype none
// Port-level checks for the ellipse region mean block.
module erm_check (
  input logic                          clk,
  input logic                          rst,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input erm_pkg::result_beat_t         out_data
);
  import erm_pkg::*;

  // Come out of reset idle with nothing to deliver
  a_reset: assert property (@(posedge clk) rst |=> !out_valid && in_ready)
    else $error("block not idle after reset");

  // One pixel in flight: ready drops after every accepted beat
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("second pixel accepted while one is in flight");

  // A stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  // Empty region gives zero mean and zero count
  a_empty: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.empty_res) |->
      (out_data.mean_value == '0) && (out_data.inside_count == '0))
    else $error("empty result carries data");

  // A non-empty region has counted pixels
  a_count: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_data.empty_res) |-> (out_data.inside_count != '0))
    else $error("non-empty result with zero count");

endmodule

bind ellipse_region_mean erm_check u_erm_check (.*);
`default_nettype wire

// ===== tb/erm_mean_checker.sv =====
`timescale 1ns / 100ps

// Watch both channels and the register port, predict the region means and
// compare every result beat with the oldest prediction.
module erm_mean_checker (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  input  logic                          in_ready,
  input  erm_pkg::pixel_beat_t          in_data,
  input  logic                          out_valid,
  input  logic                          out_ready,
  input  erm_pkg::result_beat_t         out_data,
  input  logic                          cfg_we,
  input  logic [erm_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [erm_pkg::COORD_W-1:0]   cfg_data,
  output int                            means_due,
  output int                            mismatch_count
);
  import erm_pkg::*;

  localparam logic [63:0] SUM_LIMIT   = (64'd1 << SUM_W) - 64'd1;
  localparam logic [63:0] COUNT_LIMIT = (64'd1 << CNT_W) - 64'd1;
  localparam logic [63:0] MEAN_LIMIT  = (64'd1 << MEAN_W) - 64'd1;

  logic [COORD_W-1:0] ellipse_reg [8];
  logic [63:0]        region_sum;
  logic [63:0]        region_count;
  result_beat_t       region_means [$];
  int                 errors;

  function automatic logic [63:0] reg_word(input logic [CFG_IDX_W-1:0] idx);
    return 64'(ellipse_reg[idx]);
  endfunction

  // Integer square root, rounded down, one result bit per pass.
  function automatic logic [63:0] floor_root(input logic [63:0] n);
    logic [63:0] rem;
    logic [63:0] root;
    logic [63:0] probe;
    rem   = n;
    root  = 64'd0;
    probe = 64'd1 << 62;
    while (probe > rem) probe = probe >> 2;
    while (probe != 64'd0) begin
      if (rem >= root + probe) begin
        rem  = rem - (root + probe);
        root = (root >> 1) + probe;
      end else begin
        root = root >> 1;
      end
      probe = probe >> 2;
    end
    return root;
  endfunction

  // Distance from a pixel to a focus; all coordinates are doubled, so the
  // squared sum is quartered before the root.
  function automatic logic [63:0] focus_span(input logic [63:0] px2, input logic [63:0] py2,
                                             input logic [63:0] fx2, input logic [63:0] fy2);
    logic [63:0] dx;
    logic [63:0] dy;
    dx = (px2 >= fx2) ? px2 - fx2 : fx2 - px2;
    dy = (py2 >= fy2) ? py2 - fy2 : fy2 - py2;
    return floor_root((dx * dx + dy * dy) >> 2);
  endfunction

  // Accumulate one pixel beat; on the last one, queue the region mean.
  task automatic take_pixel(input pixel_beat_t p);
    logic [63:0]  px;
    logic [63:0]  py;
    logic [63:0]  d1;
    logic [63:0]  d2;
    logic [63:0]  major;
    logic [63:0]  mean;
    result_beat_t r;
    px = 64'(p.pixel_x);
    py = 64'(p.pixel_y);
    if (px >= (reg_word(REG_LEFT_X) >> FRAC_BITS) &&
        px <= (reg_word(REG_RIGHT_X) >> FRAC_BITS) &&
        py >= (reg_word(REG_TOP_Y) >> FRAC_BITS) &&
        py <= (reg_word(REG_BOTTOM_Y) >> FRAC_BITS) &&
        reg_word(REG_CENTER_X) >= reg_word(REG_LEFT_X)) begin
      d1 = focus_span(px << (FRAC_BITS + 1), py << (FRAC_BITS + 1),
                      reg_word(REG_CENTER_X) + reg_word(REG_LEFT_X),
                      reg_word(REG_CENTER_Y) + reg_word(REG_LEFT_Y));
      d2 = focus_span(px << (FRAC_BITS + 1), py << (FRAC_BITS + 1),
                      reg_word(REG_CENTER_X) + reg_word(REG_RIGHT_X),
                      reg_word(REG_CENTER_Y) + reg_word(REG_RIGHT_Y));
      major = 64'd2 * (reg_word(REG_CENTER_X) - reg_word(REG_LEFT_X));
      if (d1 + d2 <= major) begin
        region_sum = region_sum + 64'(p.pixel_value);
        if (region_sum > SUM_LIMIT) region_sum = SUM_LIMIT;
        if (region_count < COUNT_LIMIT) region_count = region_count + 64'd1;
      end
    end
    if (p.last) begin
      if (region_count == 64'd0) begin
        r.mean_value   = '0;
        r.inside_count = '0;
        r.empty_res    = 1'b1;
      end else begin
        mean = (region_sum << MEAN_FRAC) / region_count;
        if (mean > MEAN_LIMIT) mean = MEAN_LIMIT;
        r.mean_value   = mean[MEAN_W-1:0];
        r.inside_count = region_count[CNT_W-1:0];
        r.empty_res    = 1'b0;
      end
      region_means = {region_means, r};
      region_sum   = 64'd0;
      region_count = 64'd0;
    end
  endtask

  // Compare a result beat with the oldest queued mean.
  task automatic check_mean(input result_beat_t got);
    result_beat_t want;
    if (region_means.size() == 0) begin
      errors++;
      if (errors <= 10)
        $display("%0t: unexpected result beat mean=%0d count=%0d empty=%0b",
                 $realtime, got.mean_value, got.inside_count, got.empty_res);
    end else begin
      want = region_means.pop_front();
      if (got.mean_value !== want.mean_value || got.inside_count !== want.inside_count ||
          got.empty_res !== want.empty_res) begin
        errors++;
        if (errors <= 10)
          $display("%0t: exp mean=%0d count=%0d empty=%0b, got mean=%0d count=%0d empty=%0b",
                   $realtime, want.mean_value, want.inside_count, want.empty_res,
                   got.mean_value, got.inside_count, got.empty_res);
      end
    end
  endtask

  // Track register writes, pixel beats and result beats at each edge.
  always @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 8; i++) ellipse_reg[i] = '0;
      region_sum   = 64'd0;
      region_count = 64'd0;
      region_means.delete();
      errors = 0;
    end else begin
      if (cfg_we) ellipse_reg[cfg_index] = cfg_data;
      if (in_valid && in_ready) take_pixel(in_data);
      if (out_valid && out_ready) check_mean(out_data);
    end
    means_due      <= region_means.size();
    mismatch_count <= errors;
  end

endmodule

// ===== tb/tb_ellipse_region_mean.sv =====
`timescale 1ns / 100ps

module tb_ellipse_region_mean;
  import erm_pkg::*;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int HOLD_CYCLES    = 600;
  localparam int SETTLE_CYCLES  = 80;
  localparam int RANDOM_ITEMS   = 850;

  logic                 clk       = 1'b0;
  logic                 rst       = 1'b1;
  logic                 in_valid  = 1'b0;
  logic                 in_ready;
  pixel_beat_t          in_data   = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  result_beat_t         out_data;
  logic                 cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [COORD_W-1:0]   cfg_data  = '0;
  logic                 hold_req  = 1'b0;

  int means_due;
  int mismatch_count;
  int idle_cycles = 0;
  int burst_left  = 0;
  int items_sent  = 0;
  int box_x_lo, box_x_hi, box_y_lo, box_y_hi;

  // Receiver pattern state
  int   rx_cycle  = 0;
  int   rx_mode   = 0;
  int   hold_left = 0;
  logic hold_seen = 1'b0;

  initial begin
    forever #5 clk = ~clk;
  end

  ellipse_region_mean u_top (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  erm_mean_checker u_check (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_data        (in_data),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_data       (out_data),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .means_due      (means_due),
    .mismatch_count (mismatch_count)
  );

  // Stall the result channel: change mode now and then, hold off on request.
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      rx_cycle++;
      if (rx_cycle % 48 == 0) rx_mode = $urandom_range(3, 0);
      if (hold_req && !hold_seen) hold_left = HOLD_CYCLES;
      hold_seen = hold_req;
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        case (rx_mode)
          0:       out_ready <= 1'b1;
          1:       out_ready <= 1'($urandom_range(1, 0));
          2:       out_ready <= ($urandom_range(3, 0) == 0);
          default: out_ready <= (rx_cycle % 8 >= 5);
        endcase
      end
    end
  end

  // End the run when no beat moves for too long.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  function automatic int clamp_coord(input int v);
    return (v < 0) ? 0 : (v > 65535) ? 65535 : v;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(9, 0);
    if (r < 6) return $urandom_range(4, 1);
    if (r < 9) return $urandom_range(20, 5);
    return $urandom_range(60, 21);
  endfunction

  function automatic int pick_burst();
    if ($urandom_range(9, 0) < 3) return $urandom_range(80, 20);
    return $urandom_range(6, 0);
  endfunction

  function automatic int pick_coord(input int lo, input int hi, input bit anywhere);
    int a;
    int b;
    if (anywhere) return $urandom_range(4095, 0);
    a = ((lo < hi) ? lo : hi) - 2;
    b = ((lo < hi) ? hi : lo) + 2;
    if (a < 0) a = 0;
    if (b > 4095) b = 4095;
    return $urandom_range(b, a);
  endfunction

  function automatic int pick_value();
    int r;
    r = $urandom_range(9, 0);
    if (r == 0) return 0;
    if (r == 1) return 255;
    return $urandom_range(255, 0);
  endfunction

  function automatic int pick_region_len();
    int r;
    r = $urandom_range(9, 0);
    if (r < 7) return $urandom_range(10, 1);
    if (r < 9) return $urandom_range(30, 11);
    return $urandom_range(60, 31);
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= COORD_W'(clamp_coord(value));
    @(posedge clk);
  endtask

  // Write all eight registers and note the pixel box for stimulus.
  task automatic program_ellipse(input int cx, input int cy, input int lx, input int ly,
                                 input int rx, input int ry, input int ty, input int by);
    write_reg(REG_CENTER_X, cx);
    write_reg(REG_CENTER_Y, cy);
    write_reg(REG_LEFT_X, lx);
    write_reg(REG_LEFT_Y, ly);
    write_reg(REG_RIGHT_X, rx);
    write_reg(REG_RIGHT_Y, ry);
    write_reg(REG_TOP_Y, ty);
    write_reg(REG_BOTTOM_Y, by);
    cfg_we   <= 1'b0;
    box_x_lo = clamp_coord(lx) >> FRAC_BITS;
    box_x_hi = clamp_coord(rx) >> FRAC_BITS;
    box_y_lo = clamp_coord(ty) >> FRAC_BITS;
    box_y_hi = clamp_coord(by) >> FRAC_BITS;
    @(posedge clk);
  endtask

  // Offer one pixel beat and hold it until taken; idle between bursts.
  task automatic send_pixel(input int x, input int y, input int v, input bit lst);
    pixel_beat_t p;
    p.pixel_x     = PIX_W'(x);
    p.pixel_y     = PIX_W'(y);
    p.pixel_value = VAL_W'(v);
    p.last        = lst;
    in_data  <= p;
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    items_sent++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      in_valid <= 1'b0;
      repeat (pick_gap()) @(posedge clk);
      burst_left = pick_burst();
    end
  endtask

  task automatic send_region(input int len);
    bit wide;
    wide = ($urandom_range(4, 0) == 0);
    for (int i = 0; i < len; i++)
      send_pixel(pick_coord(box_x_lo, box_x_hi, wide || $urandom_range(9, 0) == 0),
                 pick_coord(box_y_lo, box_y_hi, wide || $urandom_range(9, 0) == 0),
                 pick_value(), i == len - 1);
  endtask

  // Drop valid, wait for every queued mean, then let the pipeline settle.
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (means_due != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Stall the receiver for a long stretch while short regions keep coming.
  task automatic pressure_burst();
    hold_req <= 1'b1;
    repeat (6) send_region($urandom_range(2, 1));
    hold_req <= 1'b0;
  endtask

  task automatic random_ellipse();
    int kind, cx, cy, ax, ay, tilt;
    kind = $urandom_range(9, 0);
    cx   = $urandom_range(65535 - 700, 700);
    cy   = $urandom_range(65535 - 700, 700);
    ax   = $urandom_range(40, 8) * 16 + $urandom_range(15, 0);
    ay   = $urandom_range(40, 8) * 16 + $urandom_range(15, 0);
    tilt = $urandom_range(ax / 4, 0);
    if ($urandom_range(1, 0)) tilt = -tilt;
    case (kind)
      0: program_ellipse(32768, 32768, 0, 32768, 65535, 32768, 0, 65535);
      1: program_ellipse(cx, cy, cx + ax, cy, cx + 2 * ax, cy, cy - ay, cy + ay);
      2: begin
        if ($urandom_range(1, 0))
          program_ellipse(cx, cy, cx + ax, cy, cx - ax, cy, cy - ay, cy + ay);
        else
          program_ellipse(cx, cy, cx - ax, cy, cx + ax, cy, cy + ay, cy - ay);
      end
      3: program_ellipse($urandom_range(65535, 0), $urandom_range(65535, 0),
                         $urandom_range(65535, 0), $urandom_range(65535, 0),
                         $urandom_range(65535, 0), $urandom_range(65535, 0),
                         $urandom_range(65535, 0), $urandom_range(65535, 0));
      default: program_ellipse(cx, cy, cx - ax, cy + tilt, cx + ax, cy - tilt,
                               cy - ay, cy + ay);
    endcase
  endtask

  initial begin
    int phase;
    int start_count;
    int target;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset settings: only the origin counts; then an empty region.
    send_pixel(0, 0, 255, 1'b0);
    send_pixel(1, 0, 7, 1'b0);
    send_pixel(0, 0, 0, 1'b1);
    send_pixel(4095, 4095, 255, 1'b1);
    drain();

    // Level ellipse at (100,80), 80 wide, boxed to 40 tall: vertices, corner, edges.
    program_ellipse(1600, 1280, 960, 1280, 2240, 1280, 960, 1600);
    send_pixel(100, 80, 200, 1'b0);
    send_pixel(60, 80, 17, 1'b0);
    send_pixel(140, 80, 255, 1'b0);
    send_pixel(100, 60, 1, 1'b0);
    send_pixel(100, 100, 128, 1'b0);
    send_pixel(60, 60, 99, 1'b0);
    send_pixel(59, 80, 55, 1'b0);
    send_pixel(4095, 0, 3, 1'b0);
    send_pixel(0, 4095, 4, 1'b0);
    send_pixel(100, 80, 255, 1'b1);
    drain();

    // Center left of the left vertex: nothing counts.
    program_ellipse(800, 1280, 960, 1280, 2240, 1280, 960, 1600);
    send_pixel(60, 80, 9, 1'b0);
    send_pixel(100, 80, 90, 1'b1);
    drain();

    // Inverted column range, then inverted row range.
    program_ellipse(1600, 1280, 2240, 1280, 960, 1280, 960, 1600);
    send_pixel(100, 80, 33, 1'b1);
    drain();
    program_ellipse(1600, 1280, 960, 1280, 2240, 1280, 1600, 960);
    send_pixel(100, 80, 44, 1'b1);
    drain();

    // All registers at their top value.
    program_ellipse(65535, 65535, 65535, 65535, 65535, 65535, 65535, 65535);
    send_pixel(4095, 4095, 255, 1'b1);
    drain();

    // Random settings, each with a run of regions.
    phase       = 0;
    start_count = items_sent;
    while (items_sent - start_count < RANDOM_ITEMS) begin
      random_ellipse();
      if (phase == 1 || phase == 6) pressure_burst();
      target = items_sent + $urandom_range(100, 40);
      while (items_sent < target) send_region(pick_region_len());
      drain();
      phase++;
    end

    if (mismatch_count == 0 && means_due == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
